>>> rtl/core/eps_pkg.sv
// ----------------------------------------------------------------------------
// eps_pkg
// Shared sizes and control/status types for the spanning tree unit.
// ----------------------------------------------------------------------------
package eps_pkg;

	localparam int MAX_DOORS = 64;
	localparam int IDX_W     = $clog2(MAX_DOORS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int COORD_W   = 16;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int DIST_W    = SQ_W + 2;

	// controller to datapath
	typedef struct packed {
		logic             store;        // write incoming point at wr_addr
		logic [IDX_W-1:0] wr_addr;
		logic             clear_joined; // new set: only point 0 in the tree
		logic             scan_start;   // clear running minimum
		logic             issue;        // scan element rd_addr enters pipeline
		logic [IDX_W-1:0] rd_addr;
		logic             first;        // first round: best distance not yet valid
		logic             emit;         // load edge into output register
		logic             last_edge;
	} eps_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_busy;
	} eps_status_t;

endpackage

>>> rtl/core/eps_ram.sv
// ----------------------------------------------------------------------------
// eps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module eps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/eps_datapath.sv
// ----------------------------------------------------------------------------
// eps_datapath
// Point store, distance pipeline, best-distance store, running minimum and
// the edge output register.
// ----------------------------------------------------------------------------
module eps_datapath import eps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  eps_cmd_t           cmd,
	output eps_status_t        status,
	input  logic [COORD_W-1:0] point_x,
	input  logic [COORD_W-1:0] point_y,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [IDX_W-1:0]   parent_index,
	output logic [IDX_W-1:0]   child_index,
	output logic               last_edge
);

	localparam int XY_W   = 2 * COORD_W;
	localparam int BEST_W = DIST_W + IDX_W;

	// stores
	logic [XY_W-1:0]      xy_rd;
	logic [BEST_W-1:0]    best_rd;
	logic                 best_we;
	logic [BEST_W-1:0]    best_wd;
	logic [MAX_DOORS-1:0] joined_q;

	// current pick (last point joined)
	logic [COORD_W-1:0] px_q, py_q;
	logic [IDX_W-1:0]   pick_q;

	// pipeline
	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [IDX_W-1:0]     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                 skip_s2, skip_s3, skip_s4, skip_s5;
	logic [COORD_W-1:0]   ax_s2, ay_s2;
	logic [SQ_W-1:0]      sqx_s3, sqy_s3;
	logic [DIST_W-1:0]    d_s4, newd_s5;
	logic [BEST_W-1:0]    best_s2, best_s3, best_s4;
	logic [XY_W-1:0]      xy_s2, xy_s3, xy_s4, xy_s5;
	logic [IDX_W-1:0]     newp_s5;

	// running minimum
	logic               found_q;
	logic [DIST_W-1:0]  min_q;
	logic [IDX_W-1:0]   minv_q, minpar_q;
	logic [XY_W-1:0]    minxy_q;

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]        adx, ady;
	logic                    take;
	logic [DIST_W-1:0]       newd;
	logic [IDX_W-1:0]        newp;

	eps_ram #(.WIDTH(XY_W), .DEPTH(MAX_DOORS)) u_xy_ram (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (cmd.wr_addr),
		.wdata ({point_x, point_y}),
		.raddr (cmd.rd_addr),
		.rdata (xy_rd)
	);

	eps_ram #(.WIDTH(BEST_W), .DEPTH(MAX_DOORS)) u_best_ram (
		.clk   (clk),
		.we    (best_we),
		.waddr (v_s4),
		.wdata (best_wd),
		.raddr (cmd.rd_addr),
		.rdata (best_rd)
	);

	// stage 1: absolute coordinate differences against the pick
	always_comb begin
		dx  = $signed({xy_rd[XY_W-1], xy_rd[XY_W-1:COORD_W]}) - $signed({px_q[COORD_W-1], px_q});
		dy  = $signed({xy_rd[COORD_W-1], xy_rd[COORD_W-1:0]}) - $signed({py_q[COORD_W-1], py_q});
		adx = dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
		ady = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
	end

	// stage 4: relax the best distance, strict less-than keeps earlier parent
	always_comb begin
		take    = cmd.first || (d_s4 < best_s4[BEST_W-1:IDX_W]);
		newd    = take ? d_s4 : best_s4[BEST_W-1:IDX_W];
		newp    = take ? pick_q : best_s4[IDX_W-1:0];
		best_we = valid_s4 && !skip_s4;
		best_wd = {newd, newp};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			found_q  <= 1'b0;
			joined_q <= '0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;

			if (cmd.scan_start) begin
				found_q <= 1'b0;
			end else if (valid_s5 && !skip_s5 && (!found_q || newd_s5 < min_q)) begin
				found_q <= 1'b1;
			end

			if (cmd.clear_joined) begin
				joined_q <= MAX_DOORS'(1);
			end else if (cmd.emit) begin
				joined_q[minv_q] <= 1'b1;
			end

			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= cmd.rd_addr;
		v_s2    <= v_s1;
		skip_s2 <= joined_q[v_s1];
		ax_s2   <= adx[COORD_W-1:0];
		ay_s2   <= ady[COORD_W-1:0];
		best_s2 <= best_rd;
		xy_s2   <= xy_rd;

		v_s3    <= v_s2;
		skip_s3 <= skip_s2;
		sqx_s3  <= ax_s2 * ax_s2;
		sqy_s3  <= ay_s2 * ay_s2;
		best_s3 <= best_s2;
		xy_s3   <= xy_s2;

		v_s4    <= v_s3;
		skip_s4 <= skip_s3;
		d_s4    <= DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
		best_s4 <= best_s3;
		xy_s4   <= xy_s3;

		v_s5    <= v_s4;
		skip_s5 <= skip_s4;
		newd_s5 <= newd;
		newp_s5 <= newp;
		xy_s5   <= xy_s4;

		// lowest index wins a tie: only strictly smaller replaces
		if (valid_s5 && !skip_s5 && (!found_q || newd_s5 < min_q)) begin
			min_q    <= newd_s5;
			minv_q   <= v_s5;
			minpar_q <= newp_s5;
			minxy_q  <= xy_s5;
		end

		// point 0 is the first pick of every set
		if (cmd.store && cmd.wr_addr == '0) begin
			px_q <= point_x;
			py_q <= point_y;
		end else if (cmd.emit) begin
			px_q <= minxy_q[XY_W-1:COORD_W];
			py_q <= minxy_q[COORD_W-1:0];
		end

		if (cmd.clear_joined) begin
			pick_q <= '0;
		end else if (cmd.emit) begin
			pick_q <= minv_q;
		end

		if (cmd.emit) begin
			parent_index <= minpar_q;
			child_index  <= minv_q;
			last_edge    <= cmd.last_edge;
		end
	end

	assign status.pipe_busy = valid_s1 | valid_s2 | valid_s3 | valid_s4 | valid_s5;
	assign status.out_busy  = out_valid & out_stall;

endmodule

>>> rtl/core/eps_ctrl.sv
// ----------------------------------------------------------------------------
// eps_ctrl
// Sequencer: loads the point set, runs one scan per round over all points,
// waits for the pipeline to drain and hands each edge to the output register.
// ----------------------------------------------------------------------------
module eps_ctrl import eps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        last_point,
	input  eps_status_t status,
	output eps_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q, n_q, round_q, scan_q;
	logic [CNT_W-1:0] n_next;
	logic             first_q;
	logic             accept, room, close, last_round;

	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		accept     = in_valid && !in_stall;
		room       = (count_q < CNT_W'(MAX_DOORS));
		n_next     = count_q + CNT_W'(room);
		close      = accept && last_point && (n_next >= CNT_W'(2));
		last_round = (round_q == n_q - CNT_W'(1));

		cmd              = '0;
		cmd.wr_addr      = count_q[IDX_W-1:0];
		cmd.rd_addr      = scan_q[IDX_W-1:0];
		cmd.first        = first_q;
		cmd.last_edge    = last_round;
		unique case (state_q)
			ST_IDLE: begin
				cmd.store        = accept && room;
				cmd.clear_joined = close;
				cmd.scan_start   = close;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_EMIT: begin
				cmd.emit       = !status.out_busy;
				cmd.scan_start = !status.out_busy && !last_round;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			n_q     <= '0;
			round_q <= '0;
			scan_q  <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last_point) begin
							count_q <= '0;
							n_q     <= n_next;
							if (close) begin
								round_q <= CNT_W'(1);
								scan_q  <= '0;
								first_q <= 1'b1;
								state_q <= ST_SCAN;
							end
						end else begin
							count_q <= n_next;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + CNT_W'(1);
					if (scan_q == n_q - CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!status.out_busy) begin
						if (last_round) begin
							state_q <= ST_IDLE;
						end else begin
							round_q <= round_q + CNT_W'(1);
							first_q <= 1'b0;
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/euclidean_prim_spanning_tree_unit.sv
// ----------------------------------------------------------------------------
// euclidean_prim_spanning_tree_unit
// Euclidean minimum spanning tree of up to 64 points by Prim's method.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one point item per accepted cycle while
// idle; last_point closes the set. Points past the 64th are dropped, but a
// dropped item with last_point still closes the set.
// Output channel (out_valid/out_stall): one edge item (parent, child) per
// point joined, in joining order, last_edge on the final one. A set of one
// point gives nothing.
// Each of the n-1 rounds scans all n points through a five-stage distance
// pipeline (abs diff, square, add, relax, minimum), waits for it to drain
// and hands its edge to the output register once that is free.
// in_stall is high from set close until the final edge is in the output
// register. A stalled edge holds the output, and the sequencer waits with
// the next edge until the stall clears.
// Reset clears the sequencer, point count, tree flags and output valid; the
// point and distance stores need no clearing.
// ----------------------------------------------------------------------------
module euclidean_prim_spanning_tree_unit import eps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COORD_W-1:0] point_x,
	input  logic [COORD_W-1:0] point_y,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   parent_index,
	output logic [IDX_W-1:0]   child_index,
	output logic               last_edge
);

	eps_cmd_t    cmd;
	eps_status_t status;

	eps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.last_point (last_point),
		.status     (status),
		.cmd        (cmd)
	);

	eps_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.point_x      (point_x),
		.point_y      (point_y),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.parent_index (parent_index),
		.child_index  (child_index),
		.last_edge    (last_edge)
	);

endmodule
